// File: sv/lsbe_pkg.sv
// Package for the LED strand bit-plane encoder: item types, field widths and codes.
// It depends on nothing and is used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package lsbe_pkg;

  // Fixed lane structure: eight byte lanes in and eight plane bytes out.
  localparam int LANES     = 8;
  localparam int LANE_W    = $clog2(LANES);
  localparam int BYTE_W    = 8;

  // Strands actually wired and the longest strand supported.
  localparam int NUM_STRANDS     = 8;
  localparam int MAX_STRAND_LEDS = 512;

  // Field widths.
  localparam int LEN_W   = 10;
  localparam int LED_W   = 9;
  localparam int COMP_W  = 2;
  localparam int GPOS_W  = 11;
  localparam int CFG_IDX_W = 4;

  // Gamma store: three tables of 256 entries, addressed {component, level}.
  localparam int TABLE_AW    = 8;
  localparam int NUM_TABLES  = 3;
  localparam int GAMMA_AW    = COMP_W + TABLE_AW;
  localparam int GAMMA_DEPTH = NUM_TABLES * (1 << TABLE_AW);

  // Offset added to every plane byte.
  localparam logic [BYTE_W-1:0] BLACK_OFFSET = 8'h2C;

  // Component and table codes.
  localparam logic [COMP_W-1:0] COMP_RED   = 2'd0;
  localparam logic [COMP_W-1:0] COMP_GREEN = 2'd1;
  localparam logic [COMP_W-1:0] COMP_BLUE  = 2'd2;

  // Configuration register indexes: strand_length_0 sits at the base.
  localparam logic [CFG_IDX_W-1:0] CFG_STRAND_LEN_BASE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_REGS        = 4'd8;

  typedef enum logic {
    CMD_TABLE_WRITE = 1'b0,
    CMD_ENCODE      = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t                          cmd;
    logic [COMP_W-1:0]             table_select;
    logic [TABLE_AW-1:0]           table_index;
    logic [BYTE_W-1:0]             table_value;
    logic [LED_W-1:0]              led_index;
    logic [COMP_W-1:0]             component;
    logic [LANES*BYTE_W-1:0]       strand_bytes;
  } in_item_t;

  typedef struct packed {
    logic [LANES*BYTE_W-1:0]       frame_bytes;
    logic [GPOS_W-1:0]             group_position;
  } out_item_t;

  // Corrected levels handed from the lookup stage to the plane packer.
  typedef struct packed {
    logic [LANES-1:0][BYTE_W-1:0]  levels;
    logic [GPOS_W-1:0]             group_position;
  } level_item_t;

endpackage

`default_nettype wire

// File: sv/lsbe_gamma_bank.sv
// One copy of the three gamma tables with one write and one registered read port.
// Depends on lsbe_pkg for the table depth and address width.
`timescale 1ns / 1ps
`default_nettype none

module lsbe_gamma_bank (
  input  wire logic                             clk,
  input  wire logic                             wr_en,
  input  wire logic [lsbe_pkg::GAMMA_AW-1:0]    wr_addr,
  input  wire logic [lsbe_pkg::BYTE_W-1:0]      wr_data,
  input  wire logic                             rd_en,
  input  wire logic [lsbe_pkg::GAMMA_AW-1:0]    rd_addr,
  output logic      [lsbe_pkg::BYTE_W-1:0]      rd_data
);

  logic [lsbe_pkg::BYTE_W-1:0] mem [lsbe_pkg::GAMMA_DEPTH];
  logic [lsbe_pkg::BYTE_W-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; the data holds while the reading stage is stalled.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// File: sv/lsbe_plane_pack.sv
// Bit-plane transpose, black offset and output register of the encoder.
// Depends on lsbe_pkg for the level and result item types.
`timescale 1ns / 1ps
`default_nettype none

module lsbe_plane_pack (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     lvl_valid,
  output logic                          lvl_ready,
  input  wire lsbe_pkg::level_item_t    lvl_item,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output lsbe_pkg::out_item_t           out_item
);

  logic                 out_valid_r;
  logic                 out_valid_nxt;
  lsbe_pkg::out_item_t  out_item_r;
  lsbe_pkg::out_item_t  out_item_nxt;
  logic                 load;

  // The output register takes a new item when empty or being emptied.
  assign lvl_ready = !out_valid_r || out_ready;
  assign load      = lvl_valid && lvl_ready;

  // Plane k collects bit 7-k of every lane, lane s into bit s, then the offset.
  always_comb begin
    logic [lsbe_pkg::BYTE_W-1:0] plane;
    out_item_nxt.group_position = lvl_item.group_position;
    out_item_nxt.frame_bytes    = '0;
    for (int k = 0; k < lsbe_pkg::BYTE_W; k++) begin
      plane = '0;
      for (int s = 0; s < lsbe_pkg::LANES; s++) begin
        plane[s] = lvl_item.levels[s][lsbe_pkg::BYTE_W-1-k];
      end
      out_item_nxt.frame_bytes[k*lsbe_pkg::BYTE_W +: lsbe_pkg::BYTE_W] =
        plane + lsbe_pkg::BLACK_OFFSET;
    end
  end

  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

// File: sv/led_strand_bitplane_encoder_unit.sv
// LED strand bit-plane encoder: per-lane gamma lookup, bit-plane transpose and offset.
// Top level; depends on lsbe_pkg, lsbe_gamma_bank and lsbe_plane_pack.
`timescale 1ns / 1ps
`default_nettype none

// The block accepts one item per clock cycle, table writes and encodes alike,
// while the output side does not stall. An encode item is decoded and its LED
// index compared with each strand length into the stage 1 registers, then the
// gamma tables are read into their registered read data, then the corrected
// bytes are transposed into the output register. Every strand has its own copy of
// the three gamma tables, so each table write goes to all copies at once. A table
// write is visible to every encode item accepted after it. The gamma tables have no
// reset and need no clearing: every entry that an encode reads must have been
// written first. Table writes, encodes of component three and table writes
// with select three give no result. Strand lengths are written through the
// configuration port, which is always ready; the user must write them only while
// the block is idle, as the block itself does not enforce this.
module led_strand_bitplane_encoder_unit (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire lsbe_pkg::in_item_t                 in_item,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output lsbe_pkg::out_item_t                     out_item,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [lsbe_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [lsbe_pkg::LEN_W-1:0]         cfg_data
);

  localparam logic [lsbe_pkg::LEN_W-1:0] MAX_LEN = lsbe_pkg::LEN_W'(lsbe_pkg::MAX_STRAND_LEDS);

  // Strand length registers.
  logic [lsbe_pkg::LEN_W-1:0] strand_len_r [lsbe_pkg::LANES];

  // Stage 1: decoded item.
  logic                                 s1_valid_r;
  logic                                 s1_valid_nxt;
  lsbe_pkg::cmd_t                       s1_cmd_r;
  logic [lsbe_pkg::COMP_W-1:0]          s1_sel_r;
  logic [lsbe_pkg::TABLE_AW-1:0]        s1_tidx_r;
  logic [lsbe_pkg::BYTE_W-1:0]          s1_tval_r;
  logic [lsbe_pkg::COMP_W-1:0]          s1_comp_r;
  logic [lsbe_pkg::LANES-1:0][lsbe_pkg::BYTE_W-1:0] s1_bytes_r;
  logic [lsbe_pkg::LANES-1:0]           s1_mask_r;
  logic [lsbe_pkg::LANES-1:0]           s1_mask_nxt;
  logic [lsbe_pkg::GPOS_W-1:0]          s1_gpos_r;
  logic [lsbe_pkg::GPOS_W-1:0]          s1_gpos_nxt;

  // Stage 2: gamma read in flight.
  logic                                 s2_valid_r;
  logic                                 s2_valid_nxt;
  logic [lsbe_pkg::LANES-1:0]           s2_mask_r;
  logic [lsbe_pkg::GPOS_W-1:0]          s2_gpos_r;
  logic [lsbe_pkg::LANES-1:0][lsbe_pkg::BYTE_W-1:0] s2_rd_data;

  logic                                 in_accept;
  logic                                 in_keep;
  logic                                 s2_ready;
  logic                                 s2_load;
  logic                                 s1_go;
  logic                                 tbl_wr_en;
  logic                                 lvl_ready;
  lsbe_pkg::level_item_t                lvl_item;

  assign cfg_ready = 1'b1;

  // Configuration writes; indexes past the last strand are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < lsbe_pkg::LANES; s++) begin
        strand_len_r[s] <= '0;
      end
    end else if (cfg_valid && cfg_ready && cfg_index >= lsbe_pkg::CFG_STRAND_LEN_BASE
                 && cfg_index < lsbe_pkg::CFG_NUM_REGS) begin
      strand_len_r[cfg_index[lsbe_pkg::LANE_W-1:0]] <= cfg_data;
    end
  end

  // Pipeline flow control: each stage moves when the one after it can take.
  assign s2_ready  = !s2_valid_r || lvl_ready;
  assign s1_go     = s1_valid_r && s2_ready;
  assign s2_load   = s1_go && (s1_cmd_r == lsbe_pkg::CMD_ENCODE);
  assign tbl_wr_en = s1_go && (s1_cmd_r == lsbe_pkg::CMD_TABLE_WRITE);
  assign in_ready  = !s1_valid_r || s2_ready;
  assign in_accept = in_valid && in_ready;

  // Only items with an effect travel on: a valid table write or a valid encode.
  always_comb begin
    if (in_item.cmd == lsbe_pkg::CMD_ENCODE) begin
      in_keep = (in_item.component <= lsbe_pkg::COMP_BLUE);
    end else begin
      in_keep = (in_item.table_select <= lsbe_pkg::COMP_BLUE);
    end
  end

  // Lane enables: a strand lights this LED only if its clamped length is above the index.
  always_comb begin
    logic [lsbe_pkg::LEN_W-1:0] len_eff;
    for (int s = 0; s < lsbe_pkg::LANES; s++) begin
      len_eff = (strand_len_r[s] > MAX_LEN) ? MAX_LEN : strand_len_r[s];
      s1_mask_nxt[s] = (s < lsbe_pkg::NUM_STRANDS)
                       && ({1'b0, in_item.led_index} < len_eff);
    end
  end

  // Group position: led_index * 3 + (2 - component).
  assign s1_gpos_nxt = {2'b00, in_item.led_index}
                     + {1'b0, in_item.led_index, 1'b0}
                     + lsbe_pkg::GPOS_W'(lsbe_pkg::COMP_BLUE - in_item.component);

  always_comb begin
    if (in_accept) begin
      s1_valid_nxt = in_keep;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_comb begin
    if (s2_load) begin
      s2_valid_nxt = 1'b1;
    end else if (lvl_ready) begin
      s2_valid_nxt = 1'b0;
    end else begin
      s2_valid_nxt = s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  // Stage 1 payload.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_cmd_r   <= in_item.cmd;
      s1_sel_r   <= in_item.table_select;
      s1_tidx_r  <= in_item.table_index;
      s1_tval_r  <= in_item.table_value;
      s1_comp_r  <= in_item.component;
      s1_bytes_r <= in_item.strand_bytes;
      s1_mask_r  <= s1_mask_nxt;
      s1_gpos_r  <= s1_gpos_nxt;
    end
  end

  // Stage 2 payload beside the registered gamma reads.
  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_mask_r <= s1_mask_r;
      s2_gpos_r <= s1_gpos_r;
    end
  end

  // One table copy per wired strand; every copy takes each table write.
  for (genvar s = 0; s < lsbe_pkg::LANES; s++) begin : g_lane
    if (s < lsbe_pkg::NUM_STRANDS) begin : g_bank
      lsbe_gamma_bank u_bank (
        .clk     (clk),
        .wr_en   (tbl_wr_en),
        .wr_addr ({s1_sel_r, s1_tidx_r}),
        .wr_data (s1_tval_r),
        .rd_en   (s2_load),
        .rd_addr ({s1_comp_r, s1_bytes_r[s]}),
        .rd_data (s2_rd_data[s])
      );
    end else begin : g_none
      assign s2_rd_data[s] = '0;
    end
  end

  // Disabled strands contribute zero bits.
  always_comb begin
    for (int s = 0; s < lsbe_pkg::LANES; s++) begin
      lvl_item.levels[s] = s2_mask_r[s] ? s2_rd_data[s] : '0;
    end
    lvl_item.group_position = s2_gpos_r;
  end

  lsbe_plane_pack u_pack (
    .clk       (clk),
    .rst_n     (rst_n),
    .lvl_valid (s2_valid_r),
    .lvl_ready (lvl_ready),
    .lvl_item  (lvl_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

// File: sv/lsbe_checker.sv
// Port-level checks for the LED strand bit-plane encoder, bound to its top level.
// Depends on lsbe_pkg and watches led_strand_bitplane_encoder_unit.
`timescale 1ns / 1ps
`default_nettype none

module lsbe_checker (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  input  wire logic                               in_ready,
  input  wire lsbe_pkg::in_item_t                 in_item,
  input  wire logic                               out_valid,
  input  wire logic                               out_ready,
  input  wire lsbe_pkg::out_item_t                out_item
);

  localparam logic [lsbe_pkg::GPOS_W-1:0] GPOS_MAX = 11'd1535;

  // A result that is not taken stays and keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed or vanished while stalled");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present right after reset");

  // With the output side taking, an encode of a valid component reaches the output.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_item.cmd == lsbe_pkg::CMD_ENCODE
     && (in_item.component == lsbe_pkg::COMP_RED
         || in_item.component == lsbe_pkg::COMP_GREEN
         || in_item.component == lsbe_pkg::COMP_BLUE))
    ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("encode result missing after three cycles");

  // The group position never exceeds the last group of the longest strand.
  a_gpos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.group_position <= GPOS_MAX)
    else $error("group position out of range");

endmodule

bind led_strand_bitplane_encoder_unit lsbe_checker u_lsbe_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

`default_nettype wire

// File: sim/testbench.sv
// Testbench for the LED strand bit-plane encoder: gamma loads, a directed table, then random traffic.
// Depends on lsbe_pkg and led_strand_bitplane_encoder_unit; every result is checked in order.
`timescale 1ns / 1ps
`default_nettype none

module testbench;

  // A table select or component of three names no gamma table.
  localparam logic [lsbe_pkg::COMP_W-1:0] SEL_NONE = 2'd3;
  localparam logic [lsbe_pkg::LEN_W-1:0]  LEN_TOP  = '1;
  localparam int FRAME_W       = lsbe_pkg::LANES * lsbe_pkg::BYTE_W;
  localparam int TABLE_LEN     = 1 << lsbe_pkg::TABLE_AW;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS  = 880;
  localparam int NUM_PHASES    = 8;
  localparam int MAX_REPORTS   = 10;
  localparam int TIMEOUT_NS    = 5_000_000;

  typedef logic [lsbe_pkg::LANES-1:0][lsbe_pkg::LEN_W-1:0] len_set_t;

  typedef enum logic {
    ROW_ITEM,
    ROW_LENGTHS
  } row_kind_t;

  // One row of the directed table: an item, optionally with a typed-in result,
  // or a new set of strand lengths.
  typedef struct {
    row_kind_t           kind;
    lsbe_pkg::in_item_t  item;
    bit                  pinned;
    lsbe_pkg::out_item_t want;
    len_set_t            lens;
  } row_t;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  lsbe_pkg::in_item_t   in_item   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b1;
  lsbe_pkg::out_item_t  out_item;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [lsbe_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [lsbe_pkg::LEN_W-1:0]     cfg_data  = '0;

  // Predictor state: gamma tables and strand lengths as the block should hold them.
  logic [lsbe_pkg::BYTE_W-1:0] gamma_mem [lsbe_pkg::GAMMA_DEPTH];
  logic [lsbe_pkg::LEN_W-1:0]  strand_len [lsbe_pkg::LANES] = '{default: '0};
  lsbe_pkg::out_item_t         frame_q [$];

  row_t                 script [$];
  bit                   pinned_on;
  lsbe_pkg::out_item_t  pinned_want;
  bit                   idle_on = 1'b1;
  int                   stall_left = 0;
  int                   fail_count = 0;
  bit                   have_last_write = 1'b0;
  logic [lsbe_pkg::COMP_W-1:0]   last_sel;
  logic [lsbe_pkg::TABLE_AW-1:0] last_idx;

  led_strand_bitplane_encoder_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Gamma lookup per strand, length masking, MSB-first transpose and black offset.
  function automatic lsbe_pkg::out_item_t encode_frame(lsbe_pkg::in_item_t it);
    lsbe_pkg::out_item_t res;
    logic [lsbe_pkg::LANES-1:0][lsbe_pkg::BYTE_W-1:0] level;
    logic [lsbe_pkg::BYTE_W-1:0] plane;
    int len;
    for (int s = 0; s < lsbe_pkg::LANES; s++) begin
      len = (strand_len[s] > lsbe_pkg::MAX_STRAND_LEDS) ? lsbe_pkg::MAX_STRAND_LEDS
                                                        : int'(strand_len[s]);
      if (s < lsbe_pkg::NUM_STRANDS && int'(it.led_index) < len) begin
        level[s] = gamma_mem[{it.component,
                              it.strand_bytes[lsbe_pkg::BYTE_W*s +: lsbe_pkg::BYTE_W]}];
      end else begin
        level[s] = '0;
      end
    end
    for (int k = 0; k < lsbe_pkg::BYTE_W; k++) begin
      for (int s = 0; s < lsbe_pkg::LANES; s++) begin
        plane[s] = level[s][lsbe_pkg::BYTE_W-1-k];
      end
      res.frame_bytes[lsbe_pkg::BYTE_W*k +: lsbe_pkg::BYTE_W] = plane + lsbe_pkg::BLACK_OFFSET;
    end
    res.group_position =
      lsbe_pkg::GPOS_W'(int'(it.led_index) * 3 + 2 - int'(it.component));
    return res;
  endfunction

  // Update the predictor with an accepted item and queue the frame it should produce.
  function automatic void take_item(lsbe_pkg::in_item_t it);
    if (it.cmd == lsbe_pkg::CMD_TABLE_WRITE) begin
      if (it.table_select != SEL_NONE) begin
        gamma_mem[{it.table_select, it.table_index}] = it.table_value;
      end
    end else if (it.component != SEL_NONE) begin
      frame_q.push_back(pinned_on ? pinned_want : encode_frame(it));
    end
  endfunction

  function automatic void report(string what, logic [FRAME_W-1:0] want,
                                 logic [FRAME_W-1:0] got);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
    end
  endfunction

  function automatic void check_frame(lsbe_pkg::out_item_t got);
    lsbe_pkg::out_item_t want;
    if (frame_q.size() == 0) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS) begin
        $display("%0t: result with nothing expected: frame %h, group %0d",
                 $time, got.frame_bytes, got.group_position);
      end
    end else begin
      want = frame_q.pop_front();
      if (got.frame_bytes !== want.frame_bytes) begin
        report("frame_bytes", want.frame_bytes, got.frame_bytes);
      end
      if (got.group_position !== want.group_position) begin
        report("group_position", FRAME_W'(want.group_position),
               FRAME_W'(got.group_position));
      end
    end
  endfunction

  // Everything the block accepts or emits is seen here, at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready && cfg_index < lsbe_pkg::CFG_NUM_REGS) begin
        strand_len[lsbe_pkg::LANE_W'(cfg_index - lsbe_pkg::CFG_STRAND_LEN_BASE)] = cfg_data;
      end
      if (in_valid && in_ready) begin
        take_item(in_item);
      end
      if (out_valid && out_ready) begin
        check_frame(out_item);
      end
    end
  end

  // Result side: random stalls while idling is allowed.
  always @(negedge clk) begin
    if (!idle_on) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 3);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Every field random; callers then set the fields that matter.
  function automatic lsbe_pkg::in_item_t noise_item();
    lsbe_pkg::in_item_t it;
    it.cmd          = lsbe_pkg::cmd_t'($urandom_range(0, 1));
    it.table_select = lsbe_pkg::COMP_W'($urandom_range(0, 3));
    it.table_index  = lsbe_pkg::TABLE_AW'($urandom_range(0, TABLE_LEN - 1));
    it.table_value  = lsbe_pkg::BYTE_W'($urandom_range(0, 255));
    it.led_index    = lsbe_pkg::LED_W'($urandom_range(0, (1 << lsbe_pkg::LED_W) - 1));
    it.component    = lsbe_pkg::COMP_W'($urandom_range(0, 3));
    it.strand_bytes = {$urandom, $urandom};
    return it;
  endfunction

  function automatic lsbe_pkg::in_item_t encode_item(int led,
                                                     logic [lsbe_pkg::COMP_W-1:0] comp,
                                                     logic [FRAME_W-1:0] raw);
    lsbe_pkg::in_item_t it;
    it = noise_item();
    it.cmd          = lsbe_pkg::CMD_ENCODE;
    it.led_index    = lsbe_pkg::LED_W'(led);
    it.component    = comp;
    it.strand_bytes = raw;
    return it;
  endfunction

  function automatic lsbe_pkg::in_item_t gamma_write(logic [lsbe_pkg::COMP_W-1:0] sel,
                                                     logic [lsbe_pkg::TABLE_AW-1:0] idx,
                                                     logic [lsbe_pkg::BYTE_W-1:0] val);
    lsbe_pkg::in_item_t it;
    it = noise_item();
    it.cmd          = lsbe_pkg::CMD_TABLE_WRITE;
    it.table_select = sel;
    it.table_index  = idx;
    it.table_value  = val;
    return it;
  endfunction

  // Mostly encodes, many aimed at a strand's end or at the entry just written.
  function automatic lsbe_pkg::in_item_t random_item();
    lsbe_pkg::in_item_t it;
    int pick;
    int lane;
    pick = $urandom_range(0, 99);
    lane = $urandom_range(0, lsbe_pkg::LANES - 1);
    it = encode_item($urandom_range(0, (1 << lsbe_pkg::LED_W) - 1),
                     lsbe_pkg::COMP_W'($urandom_range(0, 2)), {$urandom, $urandom});
    if (pick < 12) begin
      it = gamma_write(lsbe_pkg::COMP_W'($urandom_range(0, 2)),
                       lsbe_pkg::TABLE_AW'($urandom_range(0, TABLE_LEN - 1)),
                       lsbe_pkg::BYTE_W'($urandom_range(0, 255)));
      last_sel = it.table_select;
      last_idx = it.table_index;
      have_last_write = 1'b1;
    end else if (pick < 15) begin
      it = gamma_write(SEL_NONE, lsbe_pkg::TABLE_AW'($urandom_range(0, TABLE_LEN - 1)),
                       lsbe_pkg::BYTE_W'($urandom_range(0, 255)));
    end else if (pick < 18) begin
      it.component = SEL_NONE;
    end else if (pick < 28 && have_last_write) begin
      it.component = last_sel;
      it.strand_bytes[lsbe_pkg::BYTE_W*lane +: lsbe_pkg::BYTE_W] = last_idx;
      it.led_index = '0;
    end else if (pick < 55) begin
      it.led_index = lsbe_pkg::LED_W'(int'(strand_len[lane]) + $urandom_range(0, 2) - 1);
    end
    if (it.cmd == lsbe_pkg::CMD_ENCODE && $urandom_range(0, 15) == 0) begin
      it.strand_bytes = $urandom_range(0, 1) ? '1 : '0;
    end
    return it;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic push_item(lsbe_pkg::in_item_t it);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Wait for all expected frames, then let items that give no result clear the pipe.
  task automatic drain();
    while (frame_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // Write all eight strand lengths, then one index past the last register.
  task automatic write_lengths(len_set_t lens);
    for (int r = 0; r <= lsbe_pkg::LANES; r++) begin
      cfg_valid <= 1'b1;
      if (r < lsbe_pkg::LANES) begin
        cfg_index <= lsbe_pkg::CFG_STRAND_LEN_BASE + lsbe_pkg::CFG_IDX_W'(r);
        cfg_data  <= lens[r];
      end else begin
        cfg_index <= lsbe_pkg::CFG_IDX_W'($urandom_range(lsbe_pkg::CFG_NUM_REGS,
                                                         (1 << lsbe_pkg::CFG_IDX_W) - 1));
        cfg_data  <= lsbe_pkg::LEN_W'($urandom_range(0, LEN_TOP));
      end
      do @(posedge clk); while (!cfg_ready);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic void add_item(lsbe_pkg::in_item_t it);
    row_t row;
    row.kind   = ROW_ITEM;
    row.item   = it;
    row.pinned = 1'b0;
    script.push_back(row);
  endfunction

  function automatic void add_pinned(lsbe_pkg::in_item_t it, logic [FRAME_W-1:0] frame,
                                     int gpos);
    row_t row;
    row.kind   = ROW_ITEM;
    row.item   = it;
    row.pinned = 1'b1;
    row.want.frame_bytes    = frame;
    row.want.group_position = lsbe_pkg::GPOS_W'(gpos);
    script.push_back(row);
  endfunction

  function automatic void add_lengths(len_set_t lens);
    row_t row;
    row.kind = ROW_LENGTHS;
    row.lens = lens;
    script.push_back(row);
  endfunction

  // Main sequence: reset, full gamma load, directed table, random phases.
  initial begin
    row_t               row;
    len_set_t           lens;
    lsbe_pkg::in_item_t it;
    int                 done;
    int                 corner_len [6] = '{0, 1, 511, 512, 513, 1023};

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Every gamma entry is written before any encode can read it.
    for (int t = 0; t < lsbe_pkg::NUM_TABLES; t++) begin
      for (int i = 0; i < TABLE_LEN; i++) begin
        push_item(gamma_write(lsbe_pkg::COMP_W'(t), lsbe_pkg::TABLE_AW'(i),
                              lsbe_pkg::BYTE_W'($urandom_range(0, 255))));
      end
    end

    // Lengths still at reset: every strand is masked.
    add_pinned(encode_item(0, lsbe_pkg::COMP_RED, '0), {lsbe_pkg::LANES{8'h2C}}, 2);
    add_pinned(encode_item(511, lsbe_pkg::COMP_BLUE, '1), {lsbe_pkg::LANES{8'h2C}}, 1533);
    add_item(encode_item(7, SEL_NONE, {$urandom, $urandom}));
    add_item(gamma_write(lsbe_pkg::COMP_RED, 8'hFF, 8'hFF));
    add_item(gamma_write(lsbe_pkg::COMP_RED, 8'h00, 8'h00));
    add_item(gamma_write(lsbe_pkg::COMP_GREEN, 8'h00, 8'hFF));
    add_item(gamma_write(SEL_NONE, 8'h00, 8'h55));
    add_item(gamma_write(lsbe_pkg::COMP_BLUE, 8'h80, 8'h01));
    // Largest length value, clamped to the longest strand.
    add_lengths({lsbe_pkg::LANES{LEN_TOP}});
    add_pinned(encode_item(511, lsbe_pkg::COMP_RED, '1), {lsbe_pkg::LANES{8'h2B}}, 1535);
    add_pinned(encode_item(0, lsbe_pkg::COMP_RED, '0), {lsbe_pkg::LANES{8'h2C}}, 2);
    add_pinned(encode_item(5, lsbe_pkg::COMP_GREEN, '0), {lsbe_pkg::LANES{8'h2B}}, 16);
    add_item(encode_item(300, lsbe_pkg::COMP_BLUE, 64'h0000_0000_8000_0000));
    add_item(encode_item(511, SEL_NONE, '1));
    // Mixed lengths, strand 7 first: only some strands reach each LED.
    add_lengths('{100, 1023, 513, 512, 511, 2, 1, 0});
    add_pinned(encode_item(0, lsbe_pkg::COMP_RED, '1), {lsbe_pkg::LANES{8'h2A}}, 2);
    add_pinned(encode_item(1, lsbe_pkg::COMP_RED, '1), {lsbe_pkg::LANES{8'h28}}, 5);
    add_pinned(encode_item(99, lsbe_pkg::COMP_RED, '1), {lsbe_pkg::LANES{8'h24}}, 299);
    add_pinned(encode_item(100, lsbe_pkg::COMP_RED, '1), {lsbe_pkg::LANES{8'hA4}}, 302);
    add_pinned(encode_item(511, lsbe_pkg::COMP_RED, '1), {lsbe_pkg::LANES{8'h9C}}, 1535);
    add_item(encode_item(510, lsbe_pkg::COMP_GREEN, '1));

    foreach (script[r]) begin
      row = script[r];
      if (row.kind == ROW_LENGTHS) begin
        in_valid <= 1'b0;
        drain();
        write_lengths(row.lens);
      end else begin
        pinned_on   = row.pinned;
        pinned_want = row.want;
        push_item(row.item);
        pinned_on   = 1'b0;
      end
    end

    // Random phases, each with its own strand lengths; the last one never idles.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      in_valid <= 1'b0;
      drain();
      for (int s = 0; s < lsbe_pkg::LANES; s++) begin
        case (ph)
          1:       lens[s] = lsbe_pkg::LEN_W'(lsbe_pkg::MAX_STRAND_LEDS);
          2:       lens[s] = lsbe_pkg::LEN_W'($urandom_range(0, LEN_TOP));
          3:       lens[s] = '0;
          4:       lens[s] = lsbe_pkg::LEN_W'(corner_len[$urandom_range(0, 5)]);
          6:       lens[s] = LEN_TOP;
          default: lens[s] = lsbe_pkg::LEN_W'($urandom_range(0, lsbe_pkg::MAX_STRAND_LEDS + 8));
        endcase
      end
      write_lengths(lens);
      idle_on = (ph != NUM_PHASES - 1);
      done = 0;
      while (done < RANDOM_ITEMS / NUM_PHASES) begin
        it = random_item();
        push_item(it);
        if (it.cmd == lsbe_pkg::CMD_ENCODE ? it.component != SEL_NONE
                                           : it.table_select != SEL_NONE) begin
          done++;
        end
      end
    end

    in_valid <= 1'b0;
    drain();
    if (fail_count == 0 && frame_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Hard stop in case the block hangs.
  initial begin
    #TIMEOUT_NS;
    $display("TEST FAILED");
    $finish;
  end

endmodule

`default_nettype wire

// File: led_strand_bitplane_encoder_unit.f
sv/lsbe_pkg.sv
sv/lsbe_gamma_bank.sv
sv/lsbe_plane_pack.sv
sv/led_strand_bitplane_encoder_unit.sv
sv/lsbe_checker.sv
sim/testbench.sv
